### rtl/core/bws_pkg.sv
// Shared types, constants and codes of the binned weighted statistics block.
package bws_pkg;

  localparam int CELL_COUNT  = 4096;
  localparam int ADDR_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 248;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_WEIGHTED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTENDED = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SUM_MODE = 2'd2;

  // item kinds
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // z result selection
  localparam logic [1:0] MODE_MEAN = 2'd0;
  localparam logic [1:0] MODE_ZSUM = 2'd1;
  localparam logic [1:0] MODE_WSUM = 2'd2;

  typedef struct packed {
    logic       weighted;
    logic       extended;
    logic [1:0] sum_mode;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [11:0]        cell_index;
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
    logic signed [23:0] z_value;
    logic [15:0]        weight;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef struct packed {
    logic pop;
    logic ready;
  } back_stat_t;

  typedef struct packed {
    logic [31:0]        wsum;
    logic signed [63:0] wx;
    logic signed [63:0] wy;
    logic signed [63:0] wz;
    logic [63:0]        wzz;
    logic [15:0]        pts;
    logic signed [23:0] low;
    logic signed [23:0] high;
  } row_t;

  typedef struct packed {
    logic [11:0]        out_cell;
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic signed [63:0] z_result;
    logic [22:0]        std_dev;
    logic               std_valid;
    logic signed [23:0] low_z;
    logic signed [23:0] high_z;
    logic [31:0]        weight_total;
    logic [15:0]        point_count;
  } result_t;

endpackage

### rtl/core/bws_front.sv
// Front end: configuration registers and the request queue toward the back end.
module bws_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  bws_pkg::item_t                 s_item_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bws_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [bws_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output bws_pkg::cfg_t                  cfg_o,
  input  bws_pkg::back_stat_t            back_i,
  output bws_pkg::queue_t                queue_o
);
  import bws_pkg::*;

  item_t             fifo_q [QUEUE_DEPTH];
  logic [QPTR_W:0]   wr_ptr_q, rd_ptr_q;
  cfg_t              cfg_q;
  logic              empty, full, push;

  assign empty = (wr_ptr_q == rd_ptr_q);
  assign full  = (wr_ptr_q[QPTR_W] != rd_ptr_q[QPTR_W]) &&
                 (wr_ptr_q[QPTR_W-1:0] == rd_ptr_q[QPTR_W-1:0]);
  assign s_ready_o   = !full && back_i.ready;
  assign push        = s_valid_i && s_ready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  assign queue_o.valid = !empty;
  assign queue_o.item  = fifo_q[rd_ptr_q[QPTR_W-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cfg_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (back_i.pop && !empty) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_WEIGHTED: cfg_q.weighted <= cfg_data_i[0];
          CFG_EXTENDED: cfg_q.extended <= cfg_data_i[0];
          CFG_SUM_MODE: cfg_q.sum_mode <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q[QPTR_W-1:0]] <= s_item_i;
  end

endmodule

### rtl/core/bws_mul.sv
// Sequential 128 by 64 bit multiplier, modulo 2^128, one 32x32 partial product a cycle.
module bws_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] p_o
);
  logic [127:0] a_q, acc_q, shifted;
  logic [63:0]  b_q;
  logic [63:0]  pp_q;
  logic [2:0]   sh_q;
  logic [3:0]   cnt_q;
  logic         run_q, done_q;
  logic [1:0]   wi;
  logic         wj;

  assign wi      = cnt_q[1:0];
  assign wj      = cnt_q[2];
  assign shifted = {64'd0, pp_q} << {sh_q, 5'd0};
  assign done_o  = done_q;
  assign p_o     = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 4'd8) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (run_q) begin
      if (cnt_q != 4'd8) begin
        pp_q <= 64'(a_q[{wi, 5'd0} +: 32]) * 64'(b_q[{wj, 5'd0} +: 32]);
        sh_q <= {1'b0, wi} + {2'b00, wj};
      end
      if (cnt_q != 4'd0) acc_q <= acc_q + shifted;
    end
  end

endmodule

### rtl/core/bws_div.sv
// Restoring 128 by 128 bit divider, one quotient bit a cycle.
module bws_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] num_i,
  input  logic [127:0] den_i,
  output logic         done_o,
  output logic [127:0] quo_o
);
  logic [127:0] n_q, d_q, q_q;
  logic [128:0] r_q, r_sh, r_sub;
  logic [6:0]   cnt_q;
  logic         run_q, done_q, fits;

  assign r_sh   = {r_q[127:0], n_q[127]};
  assign r_sub  = r_sh - {1'b0, d_q};
  assign fits   = (r_sh >= {1'b0, d_q});
  assign done_o = done_q;
  assign quo_o  = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 7'd127) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      d_q <= den_i;
      r_q <= '0;
      q_q <= '0;
    end else if (run_q) begin
      n_q <= {n_q[126:0], 1'b0};
      r_q <= fits ? r_sub : r_sh;
      q_q <= {q_q[126:0], fits};
    end
  end

endmodule

### rtl/core/bws_sqrt.sv
// Integer square root of a 46 bit value, one result bit a cycle.
module bws_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [45:0] val_i,
  output logic        done_o,
  output logic [22:0] root_o
);
  logic [45:0] v_q, bit_q;
  logic [46:0] res_q, trial;
  logic [4:0]  cnt_q;
  logic        run_q, done_q, fits;

  assign trial  = res_q + {1'b0, bit_q};
  assign fits   = ({1'b0, v_q} >= trial);
  assign done_o = done_q;
  assign root_o = res_q[22:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd22) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      bit_q <= 46'd1 << 44;
    end else if (run_q) begin
      if (fits) begin
        v_q   <= v_q - trial[45:0];
        res_q <= (res_q >> 1) + {1'b0, bit_q};
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

### rtl/core/bws_back.sv
// Back end: cell memory, read-modify-write of accumulators and the drain sequencer.
module bws_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bws_pkg::cfg_t       cfg_i,
  input  bws_pkg::queue_t     queue_i,
  output bws_pkg::back_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bws_pkg::result_t    out_o
);
  import bws_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_ACC1, S_ACC2, S_ACC3, S_DRN, S_DX, S_DY, S_DZ,
    S_MWS, S_MZ2, S_MNUM, S_MWW, S_MDEN, S_DV, S_SQ, S_OUT
  } state_e;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] umag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] signed_quo(input logic neg, input logic [63:0] q);
    if (!neg) return $signed(q);
    if (q[63]) return S64_MIN;
    return -$signed(q);
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  state_e            state_q, state_d;
  logic              issued_q, issued_d, out_valid_q, out_valid_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;

  row_t              mem_q [CELL_COUNT];
  row_t              rd_q, row_q, acc_row, mem_wdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, rd_addr;

  item_t              item_q;
  logic [15:0]        w_q;
  logic signed [40:0] px_q, py_q, pz_q;
  logic [46:0]        zsq_q;
  logic [61:0]        zz_q;
  logic signed [23:0] mx_q, my_q;
  logic signed [63:0] zr_q;
  logic [127:0]       t1_q, t2_q;
  logic [22:0]        sd_q;
  result_t            out_q;

  logic               pop, in_range;
  logic               ld_item, ld_row, ld_acc1, ld_acc2, ld_mx, ld_my, ld_zr;
  logic               ld_t1, ld_t2, ld_sd, ld_out;
  logic signed [63:0] zr_in;
  logic [127:0]       t1_in, t2_in;
  logic [22:0]        sd_in;

  logic         mul_start, mul_done, div_start, div_done, sqrt_start, sqrt_done;
  logic [127:0] mul_a, mul_p, div_num, div_den, div_quo;
  logic [63:0]  mul_b;
  logic [22:0]  sqrt_root;

  logic [15:0]        w_eff;
  logic [23:0]        zm24, n_val;
  logic [63:0]        zm64;
  logic               std_ok;
  logic signed [23:0] z_in;

  assign in_range = 32'(queue_i.item.cell_index) < CELL_COUNT;
  assign rd_addr  = ADDR_W'(queue_i.item.cell_index);
  assign w_eff    = cfg_i.weighted ? item_q.weight : 16'd256;
  assign z_in     = item_q.z_value;
  assign zm24     = z_in[23] ? 24'(-z_in) : 24'(z_in);
  assign zm64     = umag(row_q.wz);
  assign n_val    = cfg_i.weighted ? {8'd0, row_q.pts} : row_q.wsum[31:8];
  assign std_ok   = cfg_i.extended && (n_val > 24'd1);

  assign stat_o.pop   = pop;
  assign stat_o.ready = (state_q != S_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;

  // new row after one accumulate
  always_comb begin
    logic [32:0]        ws;
    logic [64:0]        zs;
    logic signed [23:0] lo_base, hi_base;
    acc_row = row_q;
    ws = {1'b0, row_q.wsum} + 33'(w_q);
    acc_row.wsum = ws[32] ? 32'hFFFF_FFFF : ws[31:0];
    acc_row.wx = sat_add(row_q.wx, 64'(px_q));
    acc_row.wy = sat_add(row_q.wy, 64'(py_q));
    acc_row.wz = sat_add(row_q.wz, 64'(pz_q));
    zs = {1'b0, row_q.wzz} + 65'(zz_q);
    lo_base = (row_q.wsum == 32'd0) ? z_in : row_q.low;
    hi_base = (row_q.wsum == 32'd0) ? z_in : row_q.high;
    if (cfg_i.extended) begin
      acc_row.wzz  = zs[64] ? 64'hFFFF_FFFF_FFFF_FFFF : zs[63:0];
      acc_row.pts  = (row_q.pts == 16'hFFFF) ? row_q.pts : row_q.pts + 16'd1;
      acc_row.low  = (z_in < lo_base) ? z_in : lo_base;
      acc_row.high = (z_in > hi_base) ? z_in : hi_base;
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = ADDR_W'(item_q.cell_index);
    mem_wdata   = '0;
    pop = 1'b0;
    ld_item = 1'b0; ld_row = 1'b0; ld_acc1 = 1'b0; ld_acc2 = 1'b0;
    ld_mx = 1'b0; ld_my = 1'b0; ld_zr = 1'b0; ld_t1 = 1'b0; ld_t2 = 1'b0;
    ld_sd = 1'b0; ld_out = 1'b0;
    zr_in = row_q.wz;
    t1_in = mul_p;
    t2_in = mul_p;
    sd_in = '0;
    mul_start = 1'b0; mul_a = '0; mul_b = '0;
    div_start = 1'b0; div_num = '0; div_den = {96'd0, row_q.wsum};
    sqrt_start = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == ADDR_W'(CELL_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (queue_i.valid) begin
          pop     = 1'b1;
          ld_item = 1'b1;
          if (in_range) state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        ld_row  = 1'b1;
        state_d = (item_q.op == OP_DRAIN) ? S_DRN : S_ACC1;
      end
      S_ACC1: begin
        ld_acc1 = 1'b1;
        state_d = S_ACC2;
      end
      S_ACC2: begin
        ld_acc2 = 1'b1;
        state_d = S_ACC3;
      end
      S_ACC3: begin
        mem_we    = 1'b1;
        mem_wdata = acc_row;
        state_d   = S_IDLE;
      end
      S_DRN: begin
        ld_sd = 1'b1;
        if (row_q.wsum == 32'd0) begin
          mem_we  = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_DX;
        end
      end
      S_DX: begin
        div_num = {64'd0, umag(row_q.wx) + 64'(row_q.wsum[31:1])};
        if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_done) begin
          ld_mx = 1'b1; issued_d = 1'b0; state_d = S_DY;
        end
      end
      S_DY: begin
        div_num = {64'd0, umag(row_q.wy) + 64'(row_q.wsum[31:1])};
        if (!issued_q) begin
          div_start = 1'b1;
          issued_d  = 1'b1;
        end else if (div_done) begin
          ld_my = 1'b1; issued_d = 1'b0; state_d = S_DZ;
        end
      end
      S_DZ: begin
        div_num = {64'd0, zm64 + 64'(row_q.wsum[31:1])};
        case (cfg_i.sum_mode)
          MODE_MEAN: begin
            zr_in = signed_quo(row_q.wz[63], div_quo[63:0]);
            if (!issued_q) begin
              div_start = 1'b1;
              issued_d  = 1'b1;
            end else if (div_done) begin
              ld_zr = 1'b1; issued_d = 1'b0; state_d = std_ok ? S_MWS : S_OUT;
            end
          end
          MODE_WSUM: begin
            zr_in = $signed({32'd0, row_q.wsum});
            ld_zr = 1'b1; state_d = std_ok ? S_MWS : S_OUT;
          end
          default: begin
            zr_in = row_q.wz;
            ld_zr = 1'b1; state_d = std_ok ? S_MWS : S_OUT;
          end
        endcase
      end
      S_MWS: begin
        mul_a = {64'd0, row_q.wzz};
        mul_b = {32'd0, row_q.wsum};
        if (!issued_q) begin
          mul_start = 1'b1; issued_d = 1'b1;
        end else if (mul_done) begin
          ld_t1 = 1'b1; issued_d = 1'b0; state_d = S_MZ2;
        end
      end
      S_MZ2: begin
        mul_a = {64'd0, zm64};
        mul_b = zm64;
        t1_in = (t1_q >= mul_p) ? t1_q - mul_p : '0;
        if (!issued_q) begin
          mul_start = 1'b1; issued_d = 1'b1;
        end else if (mul_done) begin
          ld_t1 = 1'b1; issued_d = 1'b0; state_d = S_MNUM;
        end
      end
      S_MNUM: begin
        mul_a = t1_q;
        mul_b = {40'd0, n_val};
        if (!issued_q) begin
          mul_start = 1'b1; issued_d = 1'b1;
        end else if (mul_done) begin
          ld_t1 = 1'b1; issued_d = 1'b0; state_d = S_MWW;
        end
      end
      S_MWW: begin
        mul_a = {96'd0, row_q.wsum};
        mul_b = {32'd0, row_q.wsum};
        if (!issued_q) begin
          mul_start = 1'b1; issued_d = 1'b1;
        end else if (mul_done) begin
          ld_t2 = 1'b1; issued_d = 1'b0; state_d = S_MDEN;
        end
      end
      S_MDEN: begin
        mul_a = t2_q;
        mul_b = {40'd0, n_val - 24'd1};
        if (!issued_q) begin
          mul_start = 1'b1; issued_d = 1'b1;
        end else if (mul_done) begin
          ld_t2 = 1'b1; issued_d = 1'b0; state_d = S_DV;
        end
      end
      S_DV: begin
        div_num = t1_q;
        div_den = t2_q;
        t1_in   = div_quo;
        sd_in   = 23'h7FFFFF;
        if (!issued_q) begin
          div_start = 1'b1; issued_d = 1'b1;
        end else if (div_done) begin
          issued_d = 1'b0;
          if (div_quo[127:46] != '0) begin
            ld_sd = 1'b1; state_d = S_OUT;
          end else begin
            ld_t1 = 1'b1; state_d = S_SQ;
          end
        end
      end
      S_SQ: begin
        sd_in = sqrt_root;
        if (!issued_q) begin
          sqrt_start = 1'b1; issued_d = 1'b1;
        end else if (sqrt_done) begin
          ld_sd = 1'b1; issued_d = 1'b0; state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          ld_out      = 1'b1;
          out_valid_d = 1'b1;
          mem_we      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
      clr_cnt_q   <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ld_item) item_q <= queue_i.item;
    if (ld_row)  row_q  <= rd_q;
    if (ld_acc1) begin
      w_q   <= w_eff;
      px_q  <= 41'(item_q.x_coord) * 41'($signed({1'b0, w_eff}));
      py_q  <= 41'(item_q.y_coord) * 41'($signed({1'b0, w_eff}));
      pz_q  <= 41'(item_q.z_value) * 41'($signed({1'b0, w_eff}));
      zsq_q <= 47'(zm24) * 47'(zm24);
    end
    if (ld_acc2) zz_q <= 62'(zsq_q) * 62'(w_q);
    if (ld_mx) mx_q <= sat24(signed_quo(row_q.wx[63], div_quo[63:0]));
    if (ld_my) my_q <= sat24(signed_quo(row_q.wy[63], div_quo[63:0]));
    if (ld_zr) zr_q <= zr_in;
    if (ld_t1) t1_q <= t1_in;
    if (ld_t2) t2_q <= t2_in;
    if (ld_sd) sd_q <= sd_in;
    if (ld_out) begin
      out_q.out_cell     <= item_q.cell_index;
      out_q.mean_x       <= mx_q;
      out_q.mean_y       <= my_q;
      out_q.z_result     <= zr_q;
      out_q.std_dev      <= sd_q;
      out_q.std_valid    <= std_ok;
      out_q.low_z        <= row_q.low;
      out_q.high_z       <= row_q.high;
      out_q.weight_total <= row_q.wsum;
      out_q.point_count  <= row_q.pts;
    end
  end

  bws_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  bws_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  bws_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sqrt_start), .val_i(t1_q[45:0]),
    .done_o(sqrt_done), .root_o(sqrt_root)
  );

endmodule

### rtl/core/binned_weighted_statistics.sv
// Top level of the binned weighted statistics block: stream ports and packing.
//
// The block keeps per-cell sums (weight, weighted x/y/z, weighted z squared,
// point count, low and high z) for 4096 cells in one memory row per cell.
// Each request names a cell: an accumulate adds one point, a drain reports
// the cell if its weight is nonzero and then clears it. Requests enter a
// four-deep queue; the back end handles one at a time through a
// read-modify-write of the cell memory, and the input stalls when the queue
// is full or during the clearing pass. A drain divides for the three rounded
// means (one 128-step divider shared by all divisions; two divisions when z
// is reported as a sum) and, when the standard deviation is computed, runs
// five products on the multiplier of 32x32 partial products, one more
// division and a square root. A finished result waits in an output register
// while the next requests proceed. After reset a clearing pass writes every
// cell to zero, during which s_axis_tready stays low; configuration writes
// are taken at any time and should be issued only while the block is idle.
module binned_weighted_statistics (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // cell_index, x_coord, y_coord, z_value, weight, zero pad
  input  logic [bws_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // op
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_cell, mean_x, mean_y, z_result, std_dev, low_z, high_z,
  // weight_total, point_count, zero pad
  output logic [bws_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // std_valid
  output logic [0:0]                        m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bws_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [bws_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import bws_pkg::*;

  item_t      s_item;
  cfg_t       cfg;
  queue_t     queue;
  back_stat_t back_stat;
  result_t    res;

  // unpack the input request
  always_comb begin
    s_item.op         = s_axis_tuser[0];
    s_item.cell_index = s_axis_tdata[11:0];
    s_item.x_coord    = s_axis_tdata[35:12];
    s_item.y_coord    = s_axis_tdata[59:36];
    s_item.z_value    = s_axis_tdata[83:60];
    s_item.weight     = s_axis_tdata[99:84];
  end

  bws_front u_front (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_o(s_axis_tready), .s_item_i(s_item),
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cfg_o(cfg), .back_i(back_stat), .queue_o(queue)
  );

  bws_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .queue_i(queue), .stat_o(back_stat),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_o(res)
  );

  // pack the result, lowest field first
  assign m_axis_tdata = {5'd0, res.point_count, res.weight_total, res.high_z,
                         res.low_z, res.std_dev, res.z_result, res.mean_y,
                         res.mean_x, res.out_cell};
  assign m_axis_tuser = res.std_valid;

endmodule

### rtl/core/bws_checker.sv
// Port-level assertions for the binned weighted statistics block, with its bind.
module bws_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [bws_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input logic [0:0]                        s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [bws_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [0:0]                        m_axis_tuser,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [bws_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input logic [bws_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an empty cell never reports
  a_weight_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[226:195] != 32'd0)
    else $error("result with zero weight");

  // an invalid deviation reads as zero
  a_std_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[146:124] == 23'd0)
    else $error("std_dev nonzero while flagged invalid");

  // clearing pass holds off input right after reset
  a_clear_hold: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input accepted before clearing pass");

endmodule

bind binned_weighted_statistics bws_checker u_bws_checker (.*);
